>>> rtl/frc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the framed reply checker.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package frc_pkg;

  // Frame delimiters and CRC polynomial
  localparam logic [7:0]  StartByte = 8'h7E;
  localparam logic [7:0]  StopByte  = 8'h7F;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [7:0]  AckOk     = 8'h00;

  // Largest frame accepted, in bytes (start through stop)
  localparam logic [9:0]  MaxFrameBytes = 10'd256;

  // Frame position limits and fixed offsets
  localparam logic [8:0]  PosLimit     = 9'd511;
  localparam logic [8:0]  PosStart     = 9'd0;
  localparam logic [8:0]  PosType      = 9'd1;
  localparam logic [8:0]  PosAddress   = 9'd2;
  localparam logic [8:0]  PosCommand   = 9'd3;
  localparam logic [8:0]  PosAck       = 9'd4;
  localparam logic [8:0]  PosPayload   = 9'd6;
  localparam logic [8:0]  CrcLoOffset  = 9'd6;
  localparam logic [8:0]  StopOffset   = 9'd8;
  localparam logic [9:0]  FrameOverhead = 10'd9;

  // Configuration register indexes
  localparam logic [1:0]  RegType    = 2'd0;
  localparam logic [1:0]  RegAddress = 2'd1;
  localparam logic [1:0]  RegCommand = 2'd2;
  localparam logic [1:0]  RegLength  = 2'd3;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FRAMING = 3'd1,
    ST_HEADER  = 3'd2,
    ST_ACK     = 3'd3,
    ST_CRC     = 3'd4
  } status_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0] expected_type;
    logic [7:0] expected_address;
    logic [7:0] expected_command;
    logic [7:0] payload_length;
  } cfg_t;

  // One result of the checker, plus a flag telling whether the byte produced one
  typedef struct packed {
    logic       has_result;
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    status_t    status;
  } result_t;

  // CRC-16, MSB first, one byte folded in
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/frc_cfg_regs.sv
// Configuration register file of the framed reply checker.
// Depends on frc_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps

module frc_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  input  logic         write_enable,
  input  logic [1:0]   register_index,
  input  logic [7:0]   write_data,
  output frc_pkg::cfg_t cfg
);
  import frc_pkg::*;

  // Hold register values; load the addressed one on a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_type    <= 8'd8;
      cfg.expected_address <= 8'd0;
      cfg.expected_command <= 8'd17;
      cfg.payload_length   <= 8'd7;
    end else if (write_enable) begin
      unique case (register_index)
        RegType:    cfg.expected_type    <= write_data;
        RegAddress: cfg.expected_address <= write_data;
        RegCommand: cfg.expected_command <= write_data;
        RegLength:  cfg.payload_length   <= write_data;
        default:    ;
      endcase
    end
  end

endmodule

>>> rtl/frc_frame_check.sv
// Per-byte frame tracking: position, running CRC, received CRC and first error.
// Depends on frc_pkg for constants, the CRC function and the result_t type.
`timescale 1ns / 1ps

module frc_frame_check (
  input  logic            clk,
  input  logic            rst,
  input  frc_pkg::cfg_t   cfg,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output frc_pkg::result_t result
);
  import frc_pkg::*;

  logic [8:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  status_t     first_error, first_error_next;

  logic [8:0]  crc_lo_pos;
  logic [8:0]  stop_pos;
  logic        too_long;
  status_t     byte_error;
  logic        in_payload;
  logic [8:0]  payload_offset;

  assign crc_lo_pos     = CrcLoOffset + {1'b0, cfg.payload_length};
  assign stop_pos       = StopOffset + {1'b0, cfg.payload_length};
  assign too_long       = ({2'b00, cfg.payload_length} + FrameOverhead) > MaxFrameBytes;
  assign in_payload     = (byte_position >= PosPayload) && (byte_position < crc_lo_pos);
  assign payload_offset = byte_position - PosPayload;

  // Check the fixed header fields at their positions
  always_comb begin
    byte_error = ST_OK;
    if (byte_position == PosStart) begin
      if (data_byte != StartByte) byte_error = ST_FRAMING;
    end else if (byte_position == PosType) begin
      if (data_byte != cfg.expected_type) byte_error = ST_HEADER;
    end else if (byte_position == PosAddress) begin
      if (data_byte != cfg.expected_address) byte_error = ST_HEADER;
    end else if (byte_position == PosCommand) begin
      if (data_byte != cfg.expected_command) byte_error = ST_HEADER;
    end else if (byte_position == PosAck) begin
      if (data_byte != AckOk) byte_error = ST_ACK;
    end
  end

  // Update error, CRC and position; build the result for this byte
  always_comb begin
    first_error_next = (first_error == ST_OK) ? byte_error : first_error;

    running_crc_next = running_crc;
    if ((byte_position >= PosType) && (byte_position < crc_lo_pos)) begin
      running_crc_next = crc16_byte(running_crc, data_byte);
    end

    received_crc_next = received_crc;
    if (byte_position == crc_lo_pos) begin
      received_crc_next[7:0] = data_byte;
    end
    if (byte_position == crc_lo_pos + 9'd1) begin
      received_crc_next[15:8] = data_byte;
    end

    byte_position_next = (byte_position < PosLimit) ? byte_position + 9'd1 : byte_position;

    result = '0;
    if (last_byte) begin
      result.has_result = 1'b1;
      result.is_status  = 1'b1;
      priority if ((byte_position != stop_pos) || too_long || (data_byte != StopByte)) begin
        result.status = ST_FRAMING;
      end else if (first_error_next != ST_OK) begin
        result.status = first_error_next;
      end else if (running_crc_next != received_crc_next) begin
        result.status = ST_CRC;
      end else begin
        result.status = ST_OK;
      end
      // Clear frame state for the next frame
      byte_position_next = '0;
      running_crc_next   = '0;
      received_crc_next  = '0;
      first_error_next   = ST_OK;
    end else if (in_payload) begin
      result.has_result    = 1'b1;
      result.payload_byte  = data_byte;
      result.payload_index = payload_offset[7:0];
    end
  end

  // Hold frame state; advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= '0;
      received_crc  <= '0;
      first_error   <= ST_OK;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      first_error   <= first_error_next;
    end
  end

endmodule

>>> rtl/crc16_framed_reply_checker.sv
// Top level of the CRC-16 framed reply checker: input register, frame check, result register.
// Depends on frc_pkg, frc_cfg_regs and frc_frame_check.
`timescale 1ns / 1ps

// Checks reply frames (0x7E, type, address, command, ack, length, payload,
// CRC low, CRC high, 0x7F) one byte per transfer, with last_byte marking the
// final byte. Each payload byte comes out as it arrives; the final byte gives
// one status result (0 ok, 1 framing/length, 2 header mismatch, 3 nonzero ack,
// 4 CRC mismatch, first failure in that order). The CRC is CRC-16/0x1021 with
// zero seed over type through payload. One byte is taken every clock cycle
// while the result channel does not stall; a byte passes the input register,
// the combinational CRC byte update and header compare, and lands in the
// result register. The user must write configuration only while idle (the
// block does not enforce it); it takes effect on the next byte.
module crc16_framed_reply_checker (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       write_enable,
  input  logic [1:0] register_index,
  input  logic [7:0] write_data,
  // input byte channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_status,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [2:0] status
);
  import frc_pkg::*;

  cfg_t       cfg;
  result_t    result;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       stage_advance;
  logic       out_free;

  frc_cfg_regs u_cfg_regs (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .cfg            (cfg)
  );

  frc_frame_check u_frame_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (stage_advance),
    .data_byte (stage_byte),
    .last_byte (stage_last),
    .result    (result)
  );

  // A staged byte moves on when it has no result or the result register frees up
  assign out_free      = !out_valid || out_ready;
  assign stage_advance = stage_valid && (!result.has_result || out_free);
  assign in_ready      = !stage_valid || stage_advance;

  // Input register: take a byte on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  // Result register: load a new result, drop it on an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance && result.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && result.has_result) begin
      is_status     <= result.is_status;
      payload_byte  <= result.payload_byte;
      payload_index <= result.payload_index;
      status        <= result.status;
    end
  end

endmodule
